/* rtl/sbc_pkg.sv */
// Shared types, codes and constants for the sample buffer cache.
package sbc_pkg;

  localparam int MAX_ENTRIES_DEF = 96;
  localparam int QUEUE_DEPTH_DEF = 256;

  localparam logic [1:0] OP_LOOKUP = 2'd0;
  localparam logic [1:0] OP_TICK   = 2'd1;
  localparam logic [1:0] OP_INIT   = 2'd2;
  localparam logic [1:0] OP_UNUSED = 2'd3;

  localparam logic [1:0] CFG_SHORT_COUNT = 2'd0;
  localparam logic [1:0] CFG_LONG_COUNT  = 2'd1;
  localparam logic [1:0] CFG_SHORT_BYTES = 2'd2;
  localparam logic [1:0] CFG_LONG_BYTES  = 2'd3;

  localparam logic [6:0]  SHORT_COUNT_RST = 7'd48;
  localparam logic [5:0]  LONG_COUNT_RST  = 6'd16;
  localparam logic [12:0] SHORT_BYTES_RST = 13'(144 * 9);
  localparam logic [12:0] LONG_BYTES_RST  = 13'h200;

  localparam logic [5:0] SHORT_TTL = 6'd2;
  localparam logic [5:0] LONG_TTL  = 6'd60;
  localparam logic [31:0] ALIGN_MASK = 32'hF;

  typedef struct packed {
    logic [1:0]  opcode;
    logic [31:0] dev_addr;
    logic [12:0] req_bytes;
    logic        prefer_long;
    logic [6:0]  hint_index;
  } in_item_t;

  typedef struct packed {
    logic [6:0]  buffer_index;
    logic [11:0] byte_offset;
    logic        fetch_issued;
    logic [31:0] fetch_addr;
    logic [12:0] fetch_bytes;
    logic        queue_empty_error;
  } out_item_t;

  // Effective pool bounds and buffer sizes.
  typedef struct packed {
    logic [7:0]  short_end;
    logic [7:0]  total_end;
    logic [12:0] short_bytes;
    logic [12:0] long_bytes;
  } pool_cfg_t;

endpackage

/* rtl/sample_buffer_cache_ttl.sv */
// Sample prefetch buffer cache with short-lived and long-lived pools.
// Handles one item at a time. The entry table, the queue positions and the two
// reuse queues live in synchronous memories; each step reads, checks and writes
// back. A short-pool lookup reads the hinted entry, then checks it. A long-pool
// lookup reads and checks one long entry after another. A tick visits each entry
// in use (read, then write back the aged TTL). An init sweeps max(QUEUE_DEPTH,
// MAX_ENTRIES) positions to rebuild the queues. No clearing pass
// runs after reset: the entry table starts empty through per-entry valid bits.
// The next item is accepted while a finished result still waits to be taken.
module sample_buffer_cache_ttl #(
  parameter int MAX_ENTRIES = sbc_pkg::MAX_ENTRIES_DEF,
  parameter int QUEUE_DEPTH = sbc_pkg::QUEUE_DEPTH_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  sbc_pkg::in_item_t  in_item,
  output logic               out_valid,
  input  logic               out_ready,
  output sbc_pkg::out_item_t out_item,
  input  logic               cfg_we,
  input  logic [1:0]         cfg_index,
  input  logic [12:0]        cfg_wdata
);

  localparam int EW      = $clog2(MAX_ENTRIES);
  localparam int QW      = $clog2(QUEUE_DEPTH);
  localparam int SWEEP_N = (QUEUE_DEPTH > MAX_ENTRIES) ? QUEUE_DEPTH : MAX_ENTRIES;
  localparam int SW      = $clog2(SWEEP_N);

  typedef enum logic [3:0] {
    ST_IDLE, ST_TICK_RD, ST_TICK_WR, ST_SH_RD, ST_SH_CHK,
    ST_LS_RD, ST_LS_CHK, ST_ALLOC, ST_INIT, ST_DONE
  } state_t;

  sbc_pkg::pool_cfg_t pool_cfg;

  state_t             state_r, state_nxt;
  sbc_pkg::in_item_t  item_r, item_nxt;
  sbc_pkg::out_item_t res_r, res_nxt;
  sbc_pkg::out_item_t out_data_r, out_data_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic [7:0]         idx_r, idx_nxt;
  logic [SW-1:0]      cnt_r, cnt_nxt;
  logic [QW-1:0]      shead_r, shead_nxt, stail_r, stail_nxt;
  logic [QW-1:0]      lhead_r, lhead_nxt, ltail_r, ltail_nxt;
  logic [MAX_ENTRIES-1:0] vld_r, vld_nxt;
  logic               vld_rd_r;

  logic          ent_we, pos_we, sq_we, lq_we;
  logic [EW-1:0] ent_wa, pos_wa;
  logic [37:0]   ent_wd, ent_q;
  logic [QW-1:0] pos_wd, pos_q;
  logic [QW-1:0] sq_wa, lq_wa;
  logic [7:0]    sq_wd, lq_wd, sq_q, lq_q;

  logic [31:0]   ent_src, diff, src_al;
  logic [5:0]    ent_ttl;
  logic [12:0]   buf_sz;
  logic          cov, is_short;
  logic [QW-1:0] ul_tail;
  logic [7:0]    ul_q, j8;
  logic [EW-1:0] idx_e, alloc_e, moved_e;
  logic          use_long;

  function automatic logic [QW-1:0] qnext(input logic [QW-1:0] p);
    return (32'(p) == QUEUE_DEPTH - 1) ? '0 : p + 1'b1;
  endfunction

  function automatic logic [QW-1:0] qmod(input logic [7:0] v);
    return (9'(v) >= 9'(QUEUE_DEPTH)) ? QW'(9'(v) - 9'(QUEUE_DEPTH)) : QW'(v);
  endfunction

  function automatic logic [EW-1:0] valid_ent(input logic [7:0] v);
    return (9'(v) < 9'(MAX_ENTRIES)) ? EW'(v) : '0;
  endfunction

  sbc_cfg #(.MAX_ENTRIES(MAX_ENTRIES)) u_cfg (
    .clk, .rst_n, .cfg_we, .cfg_index, .cfg_wdata, .pool_cfg
  );

  sbc_ram #(.WIDTH(38), .DEPTH(MAX_ENTRIES)) u_ent_ram (
    .clk, .we(ent_we), .waddr(ent_wa), .wdata(ent_wd), .raddr(idx_e), .rdata(ent_q)
  );

  sbc_ram #(.WIDTH(QW), .DEPTH(MAX_ENTRIES)) u_pos_ram (
    .clk, .we(pos_we), .waddr(pos_wa), .wdata(pos_wd), .raddr(idx_e), .rdata(pos_q)
  );

  sbc_ram #(.WIDTH(8), .DEPTH(QUEUE_DEPTH)) u_sq_ram (
    .clk, .we(sq_we), .waddr(sq_wa), .wdata(sq_wd), .raddr(stail_r), .rdata(sq_q)
  );

  sbc_ram #(.WIDTH(8), .DEPTH(QUEUE_DEPTH)) u_lq_ram (
    .clk, .we(lq_we), .waddr(lq_wa), .wdata(lq_wd), .raddr(ltail_r), .rdata(lq_q)
  );

  assign idx_e     = idx_r[EW-1:0];
  assign in_ready  = (state_r == ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_item  = out_data_r;

  // Entries never written since reset or init read as zero.
  assign ent_src = vld_rd_r ? ent_q[37:6] : '0;
  assign ent_ttl = vld_rd_r ? ent_q[5:0]  : '0;

  assign is_short = (state_r == ST_SH_CHK);
  assign buf_sz   = is_short ? pool_cfg.short_bytes : pool_cfg.long_bytes;
  assign diff     = item_r.dev_addr - ent_src;
  assign cov      = (item_r.req_bytes <= buf_sz) && (item_r.dev_addr >= ent_src) &&
                    (diff <= 32'(buf_sz - item_r.req_bytes));
  assign ul_tail  = is_short ? stail_r : ltail_r;
  assign ul_q     = is_short ? sq_q : lq_q;
  assign moved_e  = valid_ent(ul_q);
  assign src_al   = item_r.dev_addr & ~sbc_pkg::ALIGN_MASK;
  assign use_long = item_r.prefer_long && (ltail_r != lhead_r);
  assign alloc_e  = use_long ? valid_ent(lq_q) : valid_ent(sq_q);
  assign j8       = 8'(cnt_r);

  always_comb begin
    state_nxt     = state_r;
    item_nxt      = item_r;
    res_nxt       = res_r;
    out_data_nxt  = out_data_r;
    out_valid_nxt = out_valid_r && !out_ready;
    idx_nxt       = idx_r;
    cnt_nxt       = cnt_r;
    shead_nxt     = shead_r;
    stail_nxt     = stail_r;
    lhead_nxt     = lhead_r;
    ltail_nxt     = ltail_r;
    vld_nxt       = vld_r;
    ent_we = 1'b0; ent_wa = idx_e; ent_wd = {ent_src, ent_ttl};
    pos_we = 1'b0; pos_wa = idx_e; pos_wd = '0;
    sq_we  = 1'b0; sq_wa  = '0;    sq_wd  = '0;
    lq_we  = 1'b0; lq_wa  = '0;    lq_wd  = '0;

    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          item_nxt = in_item;
          res_nxt  = '0;
          case (in_item.opcode)
            sbc_pkg::OP_TICK: begin
              idx_nxt   = '0;
              state_nxt = (pool_cfg.total_end == '0) ? ST_DONE : ST_TICK_RD;
            end
            sbc_pkg::OP_INIT: begin
              cnt_nxt = '0;
              for (int i = 0; i < MAX_ENTRIES; i++) begin
                if (9'(i) < 9'(pool_cfg.total_end)) begin
                  vld_nxt[i] = 1'b0;
                end
              end
              stail_nxt = '0;
              shead_nxt = qmod(pool_cfg.short_end);
              ltail_nxt = '0;
              lhead_nxt = qmod(pool_cfg.total_end - pool_cfg.short_end);
              state_nxt = ST_INIT;
            end
            sbc_pkg::OP_LOOKUP: begin
              if (in_item.prefer_long || 8'(in_item.hint_index) >= pool_cfg.short_end) begin
                idx_nxt   = pool_cfg.short_end;
                state_nxt = (pool_cfg.short_end < pool_cfg.total_end) ? ST_LS_RD : ST_ALLOC;
              end else begin
                idx_nxt   = 8'(in_item.hint_index);
                state_nxt = ST_SH_RD;
              end
            end
            default: state_nxt = ST_DONE;
          endcase
        end
      end

      ST_TICK_RD: state_nxt = ST_TICK_WR;

      ST_TICK_WR: begin
        if (ent_ttl != '0) begin
          ent_we = 1'b1;
          ent_wd = {ent_src, ent_ttl - 6'd1};
          // An entry that just expired joins its reuse queue at the head position.
          if (ent_ttl == 6'd1) begin
            pos_we = 1'b1;
            if (idx_r < pool_cfg.short_end) begin
              pos_wd    = shead_r;
              sq_we     = 1'b1;
              sq_wa     = shead_r;
              sq_wd     = idx_r;
              shead_nxt = qnext(shead_r);
            end else begin
              pos_wd    = lhead_r;
              lq_we     = 1'b1;
              lq_wa     = lhead_r;
              lq_wd     = idx_r;
              lhead_nxt = qnext(lhead_r);
            end
          end
        end
        idx_nxt   = idx_r + 8'd1;
        state_nxt = (9'(idx_r) + 9'd1 < 9'(pool_cfg.total_end)) ? ST_TICK_RD : ST_DONE;
      end

      ST_SH_RD: state_nxt = ST_SH_CHK;

      ST_LS_RD: state_nxt = ST_LS_CHK;

      ST_SH_CHK, ST_LS_CHK: begin
        if (cov) begin
          ent_we = 1'b1;
          ent_wd = {ent_src, is_short ? sbc_pkg::SHORT_TTL : sbc_pkg::LONG_TTL};
          res_nxt.buffer_index = 7'(idx_r);
          res_nxt.byte_offset  = diff[11:0];
          // A queued entry leaves its queue; the oldest element fills its slot.
          if (ent_ttl == '0 && (is_short || ltail_r != lhead_r)) begin
            if (pos_q != ul_tail) begin
              pos_we = 1'b1;
              pos_wa = moved_e;
              pos_wd = pos_q;
              if (is_short) begin
                sq_we = 1'b1; sq_wa = pos_q; sq_wd = ul_q;
              end else begin
                lq_we = 1'b1; lq_wa = pos_q; lq_wd = ul_q;
              end
            end
            if (is_short) begin
              stail_nxt = qnext(stail_r);
            end else begin
              ltail_nxt = qnext(ltail_r);
            end
          end
          state_nxt = ST_DONE;
        end else if (is_short) begin
          state_nxt = ST_ALLOC;
        end else begin
          idx_nxt   = idx_r + 8'd1;
          state_nxt = (9'(idx_r) + 9'd1 < 9'(pool_cfg.total_end)) ? ST_LS_RD : ST_ALLOC;
        end
      end

      ST_ALLOC: begin
        if (use_long) begin
          ltail_nxt = qnext(ltail_r);
        end else begin
          res_nxt.queue_empty_error = (stail_r == shead_r);
          stail_nxt = qnext(stail_r);
        end
        ent_we = 1'b1;
        ent_wa = alloc_e;
        ent_wd = {src_al, sbc_pkg::SHORT_TTL};
        res_nxt.buffer_index = 7'(alloc_e);
        res_nxt.byte_offset  = {8'd0, item_r.dev_addr[3:0]};
        res_nxt.fetch_issued = 1'b1;
        res_nxt.fetch_addr   = src_al;
        res_nxt.fetch_bytes  = (8'(alloc_e) < pool_cfg.short_end) ? pool_cfg.short_bytes
                                                                  : pool_cfg.long_bytes;
        state_nxt = ST_DONE;
      end

      ST_INIT: begin
        if (9'(j8) < 9'(QUEUE_DEPTH)) begin
          sq_we = 1'b1;
          sq_wa = QW'(cnt_r);
          sq_wd = (j8 < pool_cfg.short_end) ? j8 : 8'd0;
          lq_wa = QW'(cnt_r);
          if (j8 < pool_cfg.total_end - pool_cfg.short_end) begin
            lq_we = 1'b1;
            lq_wd = j8 + pool_cfg.short_end;
          end else if (j8 >= pool_cfg.total_end) begin
            lq_we = 1'b1;
            lq_wd = pool_cfg.short_end;
          end
        end
        if (j8 < pool_cfg.total_end) begin
          pos_we = 1'b1;
          pos_wa = EW'(cnt_r);
          pos_wd = (j8 < pool_cfg.short_end) ? qmod(j8) : qmod(j8 - pool_cfg.short_end);
        end
        cnt_nxt = cnt_r + 1'b1;
        if (32'(cnt_r) == SWEEP_N - 1) begin
          state_nxt = ST_DONE;
        end
      end

      ST_DONE: begin
        if (!out_valid_r || out_ready) begin
          out_data_nxt  = res_r;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end

      default: state_nxt = ST_IDLE;
    endcase

    if (ent_we) begin
      vld_nxt[ent_wa] = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      vld_r       <= '0;
      shead_r     <= '0;
      stail_r     <= '0;
      lhead_r     <= '0;
      ltail_r     <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      vld_r       <= vld_nxt;
      shead_r     <= shead_nxt;
      stail_r     <= stail_nxt;
      lhead_r     <= lhead_nxt;
      ltail_r     <= ltail_nxt;
    end
    item_r     <= item_nxt;
    res_r      <= res_nxt;
    out_data_r <= out_data_nxt;
    idx_r      <= idx_nxt;
    cnt_r      <= cnt_nxt;
    vld_rd_r   <= vld_r[idx_e];
  end

endmodule

/* rtl/sbc_ram.sv */
// Generic single-write, single-read memory with registered read data.
module sbc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* rtl/sbc_cfg.sv */
// Configuration registers and the derived pool boundaries.
module sbc_cfg #(
  parameter int MAX_ENTRIES = sbc_pkg::MAX_ENTRIES_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_we,
  input  logic [1:0]         cfg_index,
  input  logic [12:0]        cfg_wdata,
  output sbc_pkg::pool_cfg_t pool_cfg
);

  logic [6:0]  short_count_r;
  logic [5:0]  long_count_r;
  logic [12:0] short_bytes_r;
  logic [12:0] long_bytes_r;
  logic [7:0]  short_end;
  logic [7:0]  room;
  logic [7:0]  long_used;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      short_count_r <= sbc_pkg::SHORT_COUNT_RST;
      long_count_r  <= sbc_pkg::LONG_COUNT_RST;
      short_bytes_r <= sbc_pkg::SHORT_BYTES_RST;
      long_bytes_r  <= sbc_pkg::LONG_BYTES_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        sbc_pkg::CFG_SHORT_COUNT: short_count_r <= cfg_wdata[6:0];
        sbc_pkg::CFG_LONG_COUNT:  long_count_r  <= cfg_wdata[5:0];
        sbc_pkg::CFG_SHORT_BYTES: short_bytes_r <= cfg_wdata;
        sbc_pkg::CFG_LONG_BYTES:  long_bytes_r  <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Counts that overrun the entry store saturate.
  always_comb begin
    short_end = (9'(short_count_r) < 9'(MAX_ENTRIES)) ? 8'(short_count_r)
                                                      : 8'(MAX_ENTRIES);
    room      = 8'(MAX_ENTRIES) - short_end;
    long_used = (8'(long_count_r) < room) ? 8'(long_count_r) : room;
    pool_cfg.short_end   = short_end;
    pool_cfg.total_end   = short_end + long_used;
    pool_cfg.short_bytes = short_bytes_r;
    pool_cfg.long_bytes  = long_bytes_r;
  end

endmodule

/* sim/tb.sv */
// Self-checking testbench for the two-pool sample buffer cache.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NENT = sbc_pkg::MAX_ENTRIES_DEF;
  localparam int QDEP = sbc_pkg::QUEUE_DEPTH_DEF;
  localparam int STALL_LIMIT = 5000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  sbc_pkg::in_item_t in_item = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  sbc_pkg::out_item_t out_item;
  logic cfg_we = 1'b0;
  logic [1:0] cfg_index = sbc_pkg::CFG_SHORT_COUNT;
  logic [12:0] cfg_wdata = '0;

  sample_buffer_cache_ttl i_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_item(in_item),
    .out_valid(out_valid), .out_ready(out_ready), .out_item(out_item),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  sbc_pkg::in_item_t pending_items[$];
  sbc_pkg::out_item_t expected_results[$];
  int unsigned mismatches = 0;
  bit quiet = 1'b0;

  // Shadow copy of the cache state and its registers.
  int unsigned short_cnt_reg, long_cnt_reg, short_sz_reg, long_sz_reg;
  logic [31:0] ent_src[NENT];
  int unsigned ent_ttl[NENT];
  int unsigned ent_pos[NENT];
  int unsigned sq[QDEP];
  int unsigned lq[QDEP];
  int unsigned s_head, s_tail, l_head, l_tail;

  function automatic int unsigned short_end();
    return short_cnt_reg < NENT ? short_cnt_reg : NENT;
  endfunction

  function automatic int unsigned total_end();
    int unsigned s, room;
    s = short_end();
    room = NENT - s;
    return s + (long_cnt_reg < room ? long_cnt_reg : room);
  endfunction

  function automatic int unsigned qnext(int unsigned p);
    return (p + 1 >= QDEP) ? 0 : p + 1;
  endfunction

  function automatic int unsigned clamp_entry(int unsigned v);
    return v < NENT ? v : 0;
  endfunction

  function automatic int unsigned entry_bytes(int unsigned e);
    return e < short_end() ? short_sz_reg : long_sz_reg;
  endfunction

  function automatic bit hit_in(int unsigned e, logic [31:0] addr, int unsigned req);
    int unsigned sz;
    logic [31:0] d;
    sz = entry_bytes(e);
    if (req > sz || addr < ent_src[e]) return 1'b0;
    d = addr - ent_src[e];
    return d <= sz - req;
  endfunction

  // Removes an entry from a reuse queue by moving the tail element into its slot.
  function automatic void unlink(bit long_q, int unsigned e);
    int unsigned pos, tl, moved;
    pos = ent_pos[e] % QDEP;
    tl = long_q ? l_tail : s_tail;
    if (pos != tl) begin
      moved = long_q ? lq[tl] : sq[tl];
      if (long_q) lq[pos] = moved;
      else sq[pos] = moved;
      ent_pos[clamp_entry(moved)] = pos;
    end
    if (long_q) l_tail = qnext(tl);
    else s_tail = qnext(tl);
  endfunction

  function automatic void age_pool(bit long_q, int unsigned lo, int unsigned hi);
    for (int unsigned i = lo; i < hi; i++) begin
      if (ent_ttl[i] != 0) begin
        ent_ttl[i]--;
        if (ent_ttl[i] == 0) begin
          if (long_q) begin
            ent_pos[i] = l_head;
            lq[l_head] = i;
            l_head = qnext(l_head);
          end else begin
            ent_pos[i] = s_head;
            sq[s_head] = i;
            s_head = qnext(s_head);
          end
        end
      end
    end
  endfunction

  function automatic void rebuild_queues();
    int unsigned s, t;
    s = short_end();
    t = total_end();
    for (int unsigned i = 0; i < t; i++) begin
      ent_src[i] = '0;
      ent_ttl[i] = 0;
    end
    for (int unsigned i = 0; i < QDEP; i++) sq[i] = i < s ? i : 0;
    for (int unsigned i = 0; i < s; i++) ent_pos[i] = i;
    s_tail = 0;
    s_head = s % QDEP;
    for (int unsigned i = s; i < t; i++) begin
      lq[i - s] = i;
      ent_pos[i] = (i - s) % QDEP;
    end
    for (int unsigned i = t; i < QDEP; i++) lq[i] = s;
    l_tail = 0;
    l_head = (t - s) % QDEP;
  endfunction

  function automatic sbc_pkg::out_item_t cache_step(sbc_pkg::in_item_t it);
    sbc_pkg::out_item_t r;
    int unsigned s, t, e, req, hint;
    logic [31:0] src;
    bit have, err;
    r = '0;
    s = short_end();
    t = total_end();
    req = it.req_bytes;
    hint = it.hint_index;
    have = 1'b0;
    err = 1'b0;
    e = 0;
    if (it.opcode == sbc_pkg::OP_TICK) begin
      age_pool(1'b0, 0, s);
      age_pool(1'b1, s, t);
      return r;
    end
    if (it.opcode == sbc_pkg::OP_INIT) begin
      rebuild_queues();
      return r;
    end
    if (it.opcode != sbc_pkg::OP_LOOKUP) return r;
    if (it.prefer_long || hint >= s) begin
      for (int unsigned i = s; i < t; i++) begin
        if (hit_in(i, it.dev_addr, req)) begin
          if (ent_ttl[i] == 0 && l_tail != l_head) unlink(1'b1, i);
          ent_ttl[i] = sbc_pkg::LONG_TTL;
          r.buffer_index = i[6:0];
          r.byte_offset = 12'(it.dev_addr - ent_src[i]);
          return r;
        end
      end
      if (l_tail != l_head && it.prefer_long) begin
        e = clamp_entry(lq[l_tail]);
        l_tail = qnext(l_tail);
        have = 1'b1;
      end
    end else if (hit_in(hint, it.dev_addr, req)) begin
      if (ent_ttl[hint] == 0) unlink(1'b0, hint);
      ent_ttl[hint] = sbc_pkg::SHORT_TTL;
      r.buffer_index = hint[6:0];
      r.byte_offset = 12'(it.dev_addr - ent_src[hint]);
      return r;
    end
    if (!have) begin
      err = (s_tail == s_head);
      e = clamp_entry(sq[s_tail]);
      s_tail = qnext(s_tail);
    end
    src = it.dev_addr & ~sbc_pkg::ALIGN_MASK;
    ent_ttl[e] = sbc_pkg::SHORT_TTL;
    ent_src[e] = src;
    r.buffer_index = e[6:0];
    r.byte_offset = 12'(it.dev_addr - src);
    r.fetch_issued = 1'b1;
    r.fetch_addr = src;
    r.fetch_bytes = 13'(entry_bytes(e));
    r.queue_empty_error = err;
    return r;
  endfunction

  // Stimulus bookkeeping: recent refill addresses and last returned buffer.
  logic [31:0] recent_src[8];
  int unsigned recent_wr = 0;
  logic [6:0] last_buf = '0;

  task automatic send(logic [1:0] op, logic [31:0] addr, logic [12:0] req,
                      logic pref, logic [6:0] hint);
    sbc_pkg::in_item_t it;
    sbc_pkg::out_item_t r;
    it = '{opcode: op, dev_addr: addr, req_bytes: req, prefer_long: pref,
           hint_index: hint};
    r = cache_step(it);
    if (op == sbc_pkg::OP_LOOKUP) last_buf = r.buffer_index;
    if (r.fetch_issued) begin
      recent_src[recent_wr] = r.fetch_addr;
      recent_wr = (recent_wr + 1) % 8;
    end
    pending_items.push_back(it);
    expected_results.push_back(r);
  endtask

  task automatic send_random();
    int unsigned pick;
    logic [31:0] addr;
    logic [12:0] req;
    logic [6:0] hint;
    pick = $urandom_range(0, 99);
    if (pick < 18) begin
      send(sbc_pkg::OP_TICK, $urandom, 13'($urandom), 1'($urandom), 7'($urandom));
    end else if (pick < 20) begin
      send(sbc_pkg::OP_INIT, $urandom, 13'($urandom), 1'($urandom), 7'($urandom));
    end else if (pick < 22) begin
      send(sbc_pkg::OP_UNUSED, $urandom, 13'($urandom), 1'($urandom), 7'($urandom));
    end else begin
      if ($urandom_range(0, 9) < 7)
        addr = recent_src[$urandom_range(0, 7)] + $urandom_range(0, 700);
      else
        addr = $urandom;
      req = ($urandom_range(0, 9) < 8) ? 13'($urandom_range(0, 64)) : 13'($urandom);
      hint = ($urandom_range(0, 9) < 6) ? last_buf : 7'($urandom);
      send(sbc_pkg::OP_LOOKUP, addr, req, 1'($urandom), hint);
    end
  endtask

  task automatic cfg_write(logic [1:0] idx, logic [12:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      sbc_pkg::CFG_SHORT_COUNT: short_cnt_reg = val & 13'h7F;
      sbc_pkg::CFG_LONG_COUNT:  long_cnt_reg = val & 13'h3F;
      sbc_pkg::CFG_SHORT_BYTES: short_sz_reg = val;
      default:                  long_sz_reg = val;
    endcase
  endtask

  task automatic wait_drained();
    while (pending_items.size() != 0 || expected_results.size() != 0) @(posedge clk);
    repeat (5) @(posedge clk);
  endtask

  // Driver.
  int unsigned in_gap = 0;
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!(in_valid && !in_ready)) begin
      if (in_gap != 0) begin
        in_valid <= 1'b0;
        in_gap <= in_gap - 1;
      end else if (pending_items.size() != 0) begin
        in_item <= pending_items.pop_front();
        in_valid <= 1'b1;
        if (!quiet && $urandom_range(0, 5) == 0) in_gap <= $urandom_range(1, 6);
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Monitor and receiver stalls.
  int unsigned out_gap = 0;
  always @(posedge clk) begin
    sbc_pkg::out_item_t want;
    if (rst_n) begin
      if (out_valid && out_ready) begin
        if (expected_results.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected result %p", out_item);
        end else begin
          want = expected_results.pop_front();
          if (out_item !== want) begin
            mismatches++;
            if (mismatches <= 10) $display("mismatch: expected %p actual %p", want, out_item);
          end
        end
      end
      if (out_gap != 0) begin
        out_ready <= 1'b0;
        out_gap <= out_gap - 1;
      end else begin
        out_ready <= 1'b1;
        if (!quiet && $urandom_range(0, 5) == 0) out_gap <= $urandom_range(1, 6);
      end
    end
  end

  // Watchdog on cycles without any accepted item.
  int unsigned stall_cycles = 0;
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin
    logic [12:0] cfg_set[7][4];
    short_cnt_reg = sbc_pkg::SHORT_COUNT_RST;
    long_cnt_reg = sbc_pkg::LONG_COUNT_RST;
    short_sz_reg = sbc_pkg::SHORT_BYTES_RST;
    long_sz_reg = sbc_pkg::LONG_BYTES_RST;
    for (int i = 0; i < NENT; i++) begin
      ent_src[i] = '0;
      ent_ttl[i] = 0;
      ent_pos[i] = 0;
    end
    for (int i = 0; i < QDEP; i++) begin
      sq[i] = 0;
      lq[i] = 0;
    end
    s_head = 0; s_tail = 0; l_head = 0; l_tail = 0;
    for (int i = 0; i < 8; i++) recent_src[i] = '0;
    cfg_set = '{
      '{13'd1, 13'd0, 13'd16, 13'd16},
      '{13'd64, 13'd32, 13'd4096, 13'd4096},
      '{13'h1FFF, 13'h1FFF, 13'h1FFF, 13'd0},
      '{13'd95, 13'd63, 13'd100, 13'd2000},
      '{13'd2, 13'd1, 13'd48, 13'd16},
      '{13'd20, 13'd5, 13'd700, 13'd300},
      '{13'd48, 13'd16, 13'd1296, 13'd512}
    };
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // Directed items at the reset configuration.
    send(sbc_pkg::OP_INIT, '0, '0, 1'b0, '0);
    send(sbc_pkg::OP_LOOKUP, 32'h1234, 13'd16, 1'b0, 7'd0);
    send(sbc_pkg::OP_LOOKUP, 32'h1240, 13'd100, 1'b0, 7'd0);
    send(sbc_pkg::OP_TICK, '0, '0, 1'b0, '0);
    send(sbc_pkg::OP_TICK, '0, '0, 1'b0, '0);
    send(sbc_pkg::OP_LOOKUP, 32'h1240, 13'd100, 1'b0, 7'd0);
    send(sbc_pkg::OP_LOOKUP, 32'hFFFF_FFFF, 13'd0, 1'b1, 7'd127);
    send(sbc_pkg::OP_LOOKUP, 32'hFFFF_FFF5, 13'd5, 1'b1, 7'd127);
    send(sbc_pkg::OP_LOOKUP, 32'hFFFF_FFF0, 13'h1FFF, 1'b1, 7'd127);
    send(sbc_pkg::OP_LOOKUP, 32'h0000_0040, 13'd8, 1'b0, 7'd127);
    send(sbc_pkg::OP_UNUSED, 32'hFFFF_FFFF, 13'h1FFF, 1'b1, 7'd127);
    send(sbc_pkg::OP_LOOKUP, 32'h0, 13'd0, 1'b0, 7'd5);
    send(sbc_pkg::OP_LOOKUP, 32'd1296, 13'd0, 1'b0, 7'd6);
    send(sbc_pkg::OP_LOOKUP, 32'd1200, 13'd97, 1'b0, 7'd7);
    repeat (3) send(sbc_pkg::OP_TICK, '0, '0, 1'b0, '0);
    send(sbc_pkg::OP_LOOKUP, 32'hFFFF_FFF8, 13'd8, 1'b1, 7'd40);
    send(sbc_pkg::OP_INIT, '0, '0, 1'b0, '0);
    wait_drained();

    for (int ph = 0; ph < 8; ph++) begin
      if (ph == 7) quiet = 1'b1;
      if (ph > 0) begin
        for (int k = 0; k < 4; k++) begin
          if (ph == 6) cfg_write(2'(k), 13'($urandom));
          else cfg_write(2'(k), cfg_set[ph < 6 ? ph - 1 : ph - 2][k]);
        end
      end
      send(sbc_pkg::OP_INIT, '0, '0, 1'b0, '0);
      repeat (250) send_random();
      wait_drained();
    end

    repeat (300) @(posedge clk);
    if (mismatches == 0 && expected_results.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
